// ===== sv/sam_pkg.sv =====
package sam_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DEPTH_W  = 16;
    localparam int PHASE_W  = 32;
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 16;
    localparam int MUL_P_W  = MUL_A_W + 1 + MUL_B_W;

    localparam logic [0:0] CFG_DEPTH = 1'b0;
    localparam logic [0:0] CFG_STEP  = 1'b1;

    localparam logic [15:0] DEPTH_RESET = 16'hFFFF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_end;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       block_end_out;
        logic                       effect_applied;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic b_signed;
    } t_mul_cmd;

    localparam logic [14:0] QUARTER_SINE [65] = '{
            15'd0,   15'd804,  15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
         15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512, 15'd10278, 15'd11039, 15'd11793,
        15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
        15'd18204, 15'd18867, 15'd19519, 15'd20159, 15'd20787, 15'd21402, 15'd22005, 15'd22594,
        15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
        15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
        15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
        15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
        15'd32767
    };

    // Full-wave entry from the quarter table; index 256 folds onto 0.
    function automatic logic signed [15:0] sine_entry(input logic [8:0] idx);
        logic [6:0]  k;
        logic [7:0]  mirror;
        logic [6:0]  q;
        logic [15:0] mag;
        k      = idx[6:0];
        mirror = 8'd128 - {1'b0, k};
        q      = (k <= 7'd64) ? k : mirror[6:0];
        mag    = {1'b0, QUARTER_SINE[q]};
        sine_entry = idx[7] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// ===== sv/sam_serial_mul.sv =====
module sam_serial_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sam_pkg::t_mul_cmd                  i_cmd,
    input  logic signed [sam_pkg::MUL_A_W-1:0] i_a,
    input  logic        [sam_pkg::MUL_B_W-1:0] i_b,
    output logic                               o_done,
    output logic signed [sam_pkg::MUL_P_W-1:0] o_product
);

    localparam int ACC_W = sam_pkg::MUL_A_W + 1;
    localparam int CNT_W = $clog2(sam_pkg::MUL_B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(sam_pkg::MUL_B_W - 1);

    logic signed [sam_pkg::MUL_A_W-1:0] r_a;
    logic signed [ACC_W-1:0]            r_acc, n_acc;
    logic        [sam_pkg::MUL_B_W-1:0] r_b, n_b;
    logic        [CNT_W-1:0]            r_cnt;
    logic                               r_signed;
    logic                               r_busy;
    logic                               r_done;

    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] sum;

    // Shift-right accumulate: one multiplier bit per cycle, the top bit of a
    // signed multiplier carries negative weight.
    always_comb begin
        if (!r_b[0]) begin
            addend = '0;
        end else if (r_signed && (r_cnt == LAST)) begin
            addend = -ACC_W'(r_a);
        end else begin
            addend = ACC_W'(r_a);
        end
        sum   = r_acc + addend;
        n_acc = {sum[ACC_W-1], sum[ACC_W-1:1]};
        n_b   = {sum[0], r_b[sam_pkg::MUL_B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_acc    <= '0;
            r_signed <= i_cmd.b_signed;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= n_b;
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_acc, r_b};

endmodule

// ===== sv/sine_amplitude_modulator_core.sv =====
// Tremolo: sample times an interpolated DDS sine, scaled by depth.
// Sequence: a table lookup state, three bit-serial multiplies (load plus 16 shift-add
// steps each) through one shared unit, then the output register.
// A new item is accepted only after the previous result has been loaded into the
// output register; with zero depth, the lookup and multiplies are skipped and the
// sample passes through unchanged.
// Reset (synchronous, active low): phase 0, depth 65535, step 0, no result held.
module sine_amplitude_modulator_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sam_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sam_pkg::t_out_item    o_out_data,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [1:0] P_INTERP = 2'd0;
    localparam logic [1:0] P_DEPTH  = 2'd1;
    localparam logic [1:0] P_SAMPLE = 2'd2;

    logic [1:0]                          r_state;
    logic [1:0]                          r_pass;
    logic [sam_pkg::PHASE_W-1:0]         r_phase;
    logic [sam_pkg::PHASE_W-1:0]         r_step;
    logic [sam_pkg::DEPTH_W-1:0]         r_depth;
    logic signed [sam_pkg::SAMPLE_W-1:0] r_sample;
    logic                                r_mark;
    logic                                r_bypass;
    logic signed [15:0]                  r_lo;
    logic signed [sam_pkg::SAMPLE_W-1:0] r_y;
    logic                                r_out_valid;
    sam_pkg::t_out_item                  r_out;

    sam_pkg::t_mul_cmd                  mul_cmd;
    logic signed [sam_pkg::MUL_A_W-1:0] mul_a;
    logic        [sam_pkg::MUL_B_W-1:0] mul_b;
    logic                               mul_done;
    logic signed [sam_pkg::MUL_P_W-1:0] mul_p;

    logic        in_take;
    logic        out_free;
    logic [8:0]  idx_lo, idx_hi;
    logic signed [15:0] lo, hi;
    logic signed [16:0] w_full;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign idx_lo = {1'b0, r_phase[31:24]};
    assign idx_hi = idx_lo + 9'd1;
    assign lo     = sam_pkg::sine_entry(idx_lo);
    assign hi     = sam_pkg::sine_entry(idx_hi);
    assign w_full = 17'(r_lo) + mul_p[32:16];

    always_comb begin
        mul_cmd = '0;
        mul_a   = '0;
        mul_b   = '0;
        if (r_state == S_LOOK) begin
            mul_cmd.start = 1'b1;
            mul_a         = 17'(hi) - 17'(lo);
            mul_b         = r_phase[23:8];
        end else if (r_state == S_MUL && mul_done) begin
            unique case (r_pass)
                P_INTERP: begin
                    mul_cmd.start = 1'b1;
                    mul_a         = 17'(signed'(w_full[15:0]));
                    mul_b         = r_depth;
                end
                P_DEPTH: begin
                    mul_cmd.start    = 1'b1;
                    mul_cmd.b_signed = 1'b1;
                    mul_a            = 17'(signed'(mul_p[31:16]));
                    mul_b            = r_sample;
                end
                default: begin
                    mul_cmd = '0;
                end
            endcase
        end
    end

    sam_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mul_cmd),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= P_INTERP;
            r_phase     <= '0;
            r_step      <= '0;
            r_depth     <= sam_pkg::DEPTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sam_pkg::CFG_DEPTH: r_depth <= i_cfg_data[15:0];
                    sam_pkg::CFG_STEP:  r_step  <= i_cfg_data;
                    default:            r_step  <= r_step;
                endcase
            end

            // In S_DONE the output register is either reloaded or still stalled.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= (r_depth == '0) ? S_DONE : S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_pass  <= P_INTERP;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (mul_done) begin
                        unique case (r_pass)
                            P_INTERP: r_pass <= P_DEPTH;
                            P_DEPTH:  r_pass <= P_SAMPLE;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (!r_bypass) begin
                            r_phase <= r_phase + r_step;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_in_data.sample_in;
            r_mark   <= i_in_data.block_end;
            r_bypass <= (r_depth == '0);
            r_y      <= i_in_data.sample_in;
        end
        if (r_state == S_LOOK) begin
            r_lo <= lo;
        end
        if (r_state == S_MUL && mul_done && r_pass == P_SAMPLE) begin
            r_y <= mul_p[30:15];
        end
        if (r_state == S_DONE && out_free) begin
            r_out.sample_out     <= r_y;
            r_out.block_end_out  <= r_mark;
            r_out.effect_applied <= !r_bypass;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
